[src/smf_pkg.sv]
`timescale 1ns / 1ps

package smf_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned HalfWinW  = 3;
  localparam int unsigned MaxHalfDef = 7;
  localparam logic [HalfWinW-1:0] HalfWinRst = HalfWinW'(2);

  typedef struct packed {
    logic                     first_sample;
    logic [TimeW-1:0]         sample_time;
    logic signed [ValueW-1:0] sample_value;
  } in_req_t;

  typedef struct packed {
    logic [TimeW-1:0]         centre_time;
    logic signed [ValueW-1:0] median_value;
  } out_req_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic step;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RANK,
    ST_DONE
  } state_e;

endpackage

[src/smf_cell.sv]
`timescale 1ns / 1ps

module smf_cell #(
  parameter int unsigned IDXW = 4,
  parameter int unsigned IDX  = 0
) (
  input  logic                                  clk_i,
  input  smf_pkg::cell_ctrl_t                   ctrl_i,
  input  logic [IDXW-1:0]                       len_i,
  input  logic signed [smf_pkg::ValueW-1:0]     val_left_i,
  input  logic [smf_pkg::TimeW-1:0]             time_left_i,
  input  logic signed [smf_pkg::ValueW-1:0]     probe_val_left_i,
  input  logic [IDXW-1:0]                       probe_tag_left_i,
  output logic signed [smf_pkg::ValueW-1:0]     val_o,
  output logic [smf_pkg::TimeW-1:0]             time_o,
  output logic signed [smf_pkg::ValueW-1:0]     probe_val_o,
  output logic [IDXW-1:0]                       probe_tag_o,
  output logic [IDXW-1:0]                       rank_o
);

  logic signed [smf_pkg::ValueW-1:0] val_q;
  logic [smf_pkg::TimeW-1:0]         time_q;
  logic signed [smf_pkg::ValueW-1:0] pval_q;
  logic [IDXW-1:0]                   ptag_q;
  logic [IDXW-1:0]                   rank_q;
  logic                              below;

  assign below = (ptag_q < len_i) &&
                 ((pval_q < val_q) || ((pval_q == val_q) && (ptag_q < IDXW'(IDX))));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      val_q  <= val_left_i;
      time_q <= time_left_i;
    end
    if (ctrl_i.load) begin
      pval_q <= val_q;
      ptag_q <= IDXW'(IDX);
      rank_q <= '0;
    end else if (ctrl_i.step) begin
      pval_q <= probe_val_left_i;
      ptag_q <= probe_tag_left_i;
      if (below) begin
        rank_q <= rank_q + IDXW'(1);
      end
    end
  end

  assign val_o       = val_q;
  assign time_o      = time_q;
  assign probe_val_o = pval_q;
  assign probe_tag_o = ptag_q;
  assign rank_o      = rank_q;

endmodule

[src/sliding_window_median_filter.sv]
`timescale 1ns / 1ps
// channel  | handshake                    | payload
// in       | in_valid_i / in_stall_o      | in_data_i  (smf_pkg::in_req_t)
// out      | out_valid_o / out_stall_i    | out_data_o (smf_pkg::out_req_t)
// cfg      | cfg_we_i                     | cfg_wdata_i (half window)
// An item that yields no result leaves the filter idle; one that yields a median
// goes through the load, rank and done states: a probe copy of the window rotates
// once around the 2*MAX_HALF+1 cells while every cell counts values ranked below it.
// Reset clears the sample count and the output valid; half window resets to 2.
// A new request is taken while a finished result waits under out_stall_i.

module sliding_window_median_filter #(
  parameter int unsigned MAX_HALF = smf_pkg::MaxHalfDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  smf_pkg::in_req_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output smf_pkg::out_req_t               out_data_o,
  input  logic                            cfg_we_i,
  input  logic [smf_pkg::HalfWinW-1:0]    cfg_wdata_i
);

  localparam int unsigned Depth = 2 * MAX_HALF + 1;
  localparam int unsigned IDXW  = $clog2(Depth);
  localparam int unsigned CNTW  = $clog2(Depth + 1);

  smf_pkg::state_e     state_q, state_d;
  smf_pkg::cell_ctrl_t ctrl;

  logic [smf_pkg::HalfWinW-1:0] half_window_q;
  logic [CNTW-1:0]              fill_q, fill_d, fill_base;
  logic [IDXW-1:0]              h_q, h_d, len_q, len_d;
  logic [IDXW-1:0]              step_q, step_d;
  logic                         in_acc, can_load, out_load, go_rank;
  logic                         out_valid_q, out_valid_d;
  smf_pkg::out_req_t            out_q, out_d;

  logic signed [smf_pkg::ValueW-1:0] val_w   [Depth];
  logic [smf_pkg::TimeW-1:0]         time_w  [Depth];
  logic signed [smf_pkg::ValueW-1:0] pval_w  [Depth];
  logic [IDXW-1:0]                   ptag_w  [Depth];
  logic [IDXW-1:0]                   rank_w  [Depth];
  logic [Depth-1:0]                  sel;
  logic signed [smf_pkg::ValueW-1:0] median;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    if (i == 0) begin : g_head
      smf_cell #(.IDXW(IDXW), .IDX(i)) u_cell (
        .clk_i           (clk_i),
        .ctrl_i          (ctrl),
        .len_i           (len_q),
        .val_left_i      (in_data_i.sample_value),
        .time_left_i     (in_data_i.sample_time),
        .probe_val_left_i(pval_w[Depth-1]),
        .probe_tag_left_i(ptag_w[Depth-1]),
        .val_o           (val_w[i]),
        .time_o          (time_w[i]),
        .probe_val_o     (pval_w[i]),
        .probe_tag_o     (ptag_w[i]),
        .rank_o          (rank_w[i])
      );
    end else begin : g_body
      smf_cell #(.IDXW(IDXW), .IDX(i)) u_cell (
        .clk_i           (clk_i),
        .ctrl_i          (ctrl),
        .len_i           (len_q),
        .val_left_i      (val_w[i-1]),
        .time_left_i     (time_w[i-1]),
        .probe_val_left_i(pval_w[i-1]),
        .probe_tag_left_i(ptag_w[i-1]),
        .val_o           (val_w[i]),
        .time_o          (time_w[i]),
        .probe_val_o     (pval_w[i]),
        .probe_tag_o     (ptag_w[i]),
        .rank_o          (rank_w[i])
      );
    end
  end

  assign in_acc   = in_valid_i && !in_stall_o;
  assign can_load = !out_valid_q || !out_stall_i;

  always_comb begin
    if (int'(half_window_q) > int'(MAX_HALF)) begin
      h_d = IDXW'(MAX_HALF);
    end else begin
      h_d = IDXW'(half_window_q);
    end
    len_d     = IDXW'({h_d, 1'b1});
    fill_base = in_data_i.first_sample ? '0 : fill_q;
    fill_d    = (fill_base < CNTW'(Depth)) ? fill_base + CNTW'(1) : fill_base;
    go_rank   = fill_d >= CNTW'(len_d);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      smf_pkg::ST_IDLE: begin
        if (in_acc && go_rank) begin
          state_d = smf_pkg::ST_LOAD;
        end
      end
      smf_pkg::ST_LOAD: state_d = smf_pkg::ST_RANK;
      smf_pkg::ST_RANK: begin
        if (step_q == IDXW'(Depth - 1)) begin
          state_d = smf_pkg::ST_DONE;
        end
      end
      smf_pkg::ST_DONE: begin
        if (can_load) begin
          state_d = smf_pkg::ST_IDLE;
        end
      end
      default: state_d = smf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != smf_pkg::ST_IDLE);
    ctrl.shift = (state_q == smf_pkg::ST_IDLE) && in_valid_i;
    ctrl.load  = (state_q == smf_pkg::ST_LOAD);
    ctrl.step  = (state_q == smf_pkg::ST_RANK);
    out_load   = (state_q == smf_pkg::ST_DONE) && can_load;
    step_d     = ctrl.step ? step_q + IDXW'(1) : '0;
  end

  always_comb begin
    median = '0;
    for (int i = 0; i < Depth; i++) begin
      sel[i] = (IDXW'(i) < len_q) && (rank_w[i] == h_q);
      if (sel[i]) begin
        median = median | val_w[i];
      end
    end
    out_d.centre_time  = time_w[h_q];
    out_d.median_value = median;
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= smf_pkg::ST_IDLE;
      half_window_q <= smf_pkg::HalfWinRst;
      fill_q        <= '0;
      out_valid_q   <= 1'b0;
      step_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      if (cfg_we_i) begin
        half_window_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      h_q   <= h_d;
      len_q <= len_d;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_one_median: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == smf_pkg::ST_DONE) |-> $onehot(sel))
    else $error("median select not one-hot");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNTW'(Depth))
    else $error("sample count beyond window depth");

  a_rank_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == smf_pkg::ST_LOAD) |-> (fill_q >= CNTW'(len_q)))
    else $error("ranking started on a short window");

  a_load_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(out_q))
    else $error("pending result overwritten");

endmodule
